### design/jsd_pkg.sv
package jsd_pkg;

    localparam int LOG_FRAC = 24;
    localparam int MANT_FRAC = 30;
    localparam int PROB_W = 17;
    localparam int SUM_W = PROB_W + 1;
    localparam int TAB_W = LOG_FRAC + 1;
    localparam int LOG_W = 29;
    localparam int WGT_W = 31;
    localparam int MUL_B_W = PROB_W + 1;
    localparam int PROD_W = WGT_W + MUL_B_W;
    localparam int E_W = PROD_W + 1;
    localparam int ACC_W = 48;
    localparam int DIV_W = 41;
    localparam int SKIP_W = 14;
    localparam int K_W = 5;

    typedef enum logic [1:0] {
        OPND_S = 2'd0,
        OPND_P = 2'd1,
        OPND_Q = 2'd2
    } opnd_sel_t;

    typedef enum logic [1:0] {
        MUL_LOG = 2'd0,
        MUL_P   = 2'd1,
        MUL_Q   = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic      load_in;
        logic      prep_en;
        opnd_sel_t prep_sel;
        logic      mul_en;
        mul_sel_t  mul_sel;
        logic      fin_en;
        opnd_sel_t fin_sel;
        logic      wp_en;
        logic      wq_en;
        logic      e_init;
        logic      e_add;
        logic      acc_en;
        logic      emit;
    } jsd_cmd_t;

    typedef struct packed {
        logic last;
    } jsd_status_t;

    // log2 of mantissa 1 + idx/2^tbits, 24 fraction bits, by repeated squaring
    function automatic logic [TAB_W-1:0] log_tab_entry(int unsigned idx, int unsigned tbits);
        longint unsigned y;
        longint unsigned v;
        int unsigned rbits;
        rbits = MANT_FRAC - tbits;
        v = 64'd0;
        if (idx >= (32'd1 << tbits)) begin
            return TAB_W'(64'd1 << LOG_FRAC);
        end
        y = (64'd1 << MANT_FRAC) + (64'(idx) << rbits);
        for (int b = 0; b < 25; b++) begin
            y = (y * y) >> MANT_FRAC;
            v = v << 1;
            if (y >= (64'd1 << (MANT_FRAC + 1))) begin
                y = y >> 1;
                v = v | 64'd1;
            end
        end
        return TAB_W'((v + 64'd1) >> 1);
    endfunction

endpackage

### design/jsd_ctrl.sv
module jsd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  jsd_pkg::jsd_status_t status,
    output jsd_pkg::jsd_cmd_t    cmd
);
    import jsd_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_PS   = 10'b00_0000_0010,
        ST_PP   = 10'b00_0000_0100,
        ST_PQ   = 10'b00_0000_1000,
        ST_MQ   = 10'b00_0001_0000,
        ST_FQ   = 10'b00_0010_0000,
        ST_WP   = 10'b00_0100_0000,
        ST_XQ   = 10'b00_1000_0000,
        ST_EQ   = 10'b01_0000_0000,
        ST_AC   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_busy;

    assign out_busy  = out_valid_reg && !out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = ST_PS;
                end
            end
            ST_PS:
            begin
                cmd.prep_en  = 1'b1;
                cmd.prep_sel = OPND_S;
                state_next   = ST_PP;
            end
            ST_PP:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_LOG;
                cmd.prep_en  = 1'b1;
                cmd.prep_sel = OPND_P;
                state_next   = ST_PQ;
            end
            ST_PQ:
            begin
                cmd.fin_en   = 1'b1;
                cmd.fin_sel  = OPND_S;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_LOG;
                cmd.prep_en  = 1'b1;
                cmd.prep_sel = OPND_Q;
                state_next   = ST_MQ;
            end
            ST_MQ:
            begin
                cmd.fin_en  = 1'b1;
                cmd.fin_sel = OPND_P;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LOG;
                state_next  = ST_FQ;
            end
            ST_FQ:
            begin
                cmd.fin_en  = 1'b1;
                cmd.fin_sel = OPND_Q;
                cmd.wp_en   = 1'b1;
                state_next  = ST_WP;
            end
            ST_WP:
            begin
                cmd.wq_en   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_P;
                state_next  = ST_XQ;
            end
            ST_XQ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_Q;
                cmd.e_init  = 1'b1;
                state_next  = ST_EQ;
            end
            ST_EQ:
            begin
                cmd.e_add  = 1'b1;
                state_next = ST_AC;
            end
            ST_AC:
            begin
                // on the final element, hold while the previous result beat is still waiting
                if (!(status.last && out_busy))
                begin
                    cmd.acc_en = 1'b1;
                    cmd.emit   = status.last;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken beat");

    a_rose_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_AC))
        else $error("result appeared outside the accumulate step");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an element is in flight");

    a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (status.last && cmd.acc_en))
        else $error("result emitted for a non-final element");

endmodule

### design/jsd_datapath.sv
module jsd_datapath #(
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [jsd_pkg::PROB_W-1:0]         prob_a,
    input  logic [jsd_pkg::PROB_W-1:0]         prob_b,
    input  logic                               last_element,
    input  jsd_pkg::jsd_cmd_t                  cmd,
    output jsd_pkg::jsd_status_t               status,
    output logic signed [jsd_pkg::DIV_W-1:0]   divergence,
    output logic [jsd_pkg::SKIP_W-1:0]         skipped_terms
);
    import jsd_pkg::*;

    localparam int IDX_W = LOG_TABLE_BITS;
    localparam int RT_W = PROB_W - LOG_TABLE_BITS;
    localparam int TAB_ENTRIES = (1 << LOG_TABLE_BITS) + 1;
    localparam logic [SKIP_W:0] SKIP_MAX = {1'b0, {SKIP_W{1'b1}}};

    logic [TAB_W-1:0] log_tab [TAB_ENTRIES];

    for (genvar g = 0; g < TAB_ENTRIES; g++)
    begin : g_tab
        localparam logic [TAB_W-1:0] ENTRY = log_tab_entry(g, LOG_TABLE_BITS);
        assign log_tab[g] = ENTRY;
    end

    // input beat
    logic [PROB_W-1:0] p_reg, q_reg;
    logic              last_reg;

    // log prep stage
    logic [SUM_W-1:0]  opnd;
    logic [K_W-1:0]    k_val;
    logic [SUM_W-1:0]  norm;
    logic [IDX_W-1:0]  idx;
    logic [RT_W-1:0]   rt;
    logic [TAB_W-1:0]  t0, t1;
    logic [K_W-1:0]    pk_reg;
    logic [TAB_W-1:0]  pt_reg, pd_reg;
    logic [RT_W-1:0]   prt_reg;

    // shared multiplier
    logic signed [WGT_W-1:0]   a_op;
    logic signed [MUL_B_W-1:0] b_op;
    logic signed [PROD_W-1:0]  mul_res;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [LOG_W-1:0]          base_reg;

    logic [LOG_W-1:0]        lval;
    logic [LOG_W-1:0]        ls_reg, lp_reg, lq_reg;
    logic signed [WGT_W-1:0] wp_reg, wq_reg;
    logic signed [E_W-1:0]   e_reg;
    logic signed [E_W-1:0]   prod_ext;

    // accumulate
    logic signed [E_W-1:0]    e_rnd;
    logic signed [E_W-18:0]   inc;
    logic signed [ACC_W+1:0]  sum_wide;
    logic signed [ACC_W-1:0]  sum_sat;
    logic signed [DIV_W-1:0]  div_sat;
    logic signed [ACC_W-1:0]  sum_reg;
    logic [SKIP_W-1:0]        cnt_reg;
    logic [1:0]               zeros;
    logic [SKIP_W:0]          cnt_wide;
    logic [SKIP_W-1:0]        cnt_sat;
    logic signed [DIV_W-1:0]  div_reg;
    logic [SKIP_W-1:0]        skip_reg;

    always_comb
    begin
        unique case (cmd.prep_sel)
            OPND_S:  opnd = SUM_W'(p_reg) + SUM_W'(q_reg);
            OPND_P:  opnd = SUM_W'(p_reg);
            OPND_Q:  opnd = SUM_W'(q_reg);
            default: opnd = '0;
        endcase
    end

    always_comb
    begin
        k_val = '0;
        for (int b = 0; b < SUM_W; b++)
        begin
            if (opnd[b])
            begin
                k_val = K_W'(b);
            end
        end
    end

    // leading one to bit SUM_W-1; the bits below it are the top mantissa fraction bits
    assign norm = opnd << (K_W'(SUM_W - 1) - k_val);
    assign idx  = norm[SUM_W-2 -: IDX_W];
    assign rt   = norm[RT_W-1:0];
    assign t0   = log_tab[(IDX_W+1)'(idx)];
    assign t1   = log_tab[(IDX_W+1)'(idx) + (IDX_W+1)'(1)];

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_LOG:
            begin
                a_op = WGT_W'(pd_reg);
                b_op = MUL_B_W'(prt_reg);
            end
            MUL_P:
            begin
                a_op = wp_reg;
                b_op = MUL_B_W'(p_reg);
            end
            MUL_Q:
            begin
                a_op = wq_reg;
                b_op = MUL_B_W'(q_reg);
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    assign mul_res = a_op * b_op;
    assign lval    = base_reg + prod_reg[RT_W +: LOG_W];

    // a term with zero probability contributes nothing
    always_comb
    begin
        prod_ext = E_W'(prod_reg);
        if (cmd.e_init && p_reg == '0)
        begin
            prod_ext = '0;
        end
        if (cmd.e_add && q_reg == '0)
        begin
            prod_ext = '0;
        end
    end

    // half of e in 2^-24 units, rounded half up
    assign e_rnd    = e_reg + E_W'(65536);
    assign inc      = e_rnd[E_W-1:17];
    assign sum_wide = (ACC_W+2)'(sum_reg) + (ACC_W+2)'(inc);

    always_comb
    begin
        if (sum_wide[ACC_W+1:ACC_W-1] != '0 && sum_wide[ACC_W+1:ACC_W-1] != '1)
        begin
            sum_sat = sum_wide[ACC_W+1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                        : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[ACC_W-1:0];
        end
    end

    always_comb
    begin
        if (sum_sat[ACC_W-1:DIV_W-1] != '0 && sum_sat[ACC_W-1:DIV_W-1] != '1)
        begin
            div_sat = sum_sat[ACC_W-1] ? {1'b1, {(DIV_W-1){1'b0}}}
                                       : {1'b0, {(DIV_W-1){1'b1}}};
        end
        else
        begin
            div_sat = sum_sat[DIV_W-1:0];
        end
    end

    assign zeros    = 2'(p_reg == '0) + 2'(q_reg == '0);
    assign cnt_wide = (SKIP_W+1)'(cnt_reg) + (SKIP_W+1)'(zeros);
    assign cnt_sat  = (cnt_wide > SKIP_MAX) ? SKIP_MAX[SKIP_W-1:0] : cnt_wide[SKIP_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            p_reg    <= prob_a;
            q_reg    <= prob_b;
            last_reg <= last_element;
        end
        if (cmd.prep_en)
        begin
            pk_reg  <= k_val;
            pt_reg  <= t0;
            pd_reg  <= t1 - t0;
            prt_reg <= rt;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_res;
            base_reg <= {pk_reg, {LOG_FRAC{1'b0}}} + LOG_W'(pt_reg);
        end
        if (cmd.fin_en)
        begin
            unique case (cmd.fin_sel)
                OPND_S:  ls_reg <= lval;
                OPND_P:  lp_reg <= lval;
                OPND_Q:  lq_reg <= lval;
                default: ls_reg <= lval;
            endcase
        end
        if (cmd.wp_en)
        begin
            wp_reg <= WGT_W'(1 << LOG_FRAC) + WGT_W'(lp_reg) - WGT_W'(ls_reg);
        end
        if (cmd.wq_en)
        begin
            wq_reg <= WGT_W'(1 << LOG_FRAC) + WGT_W'(lq_reg) - WGT_W'(ls_reg);
        end
        if (cmd.e_init)
        begin
            e_reg <= prod_ext;
        end
        else if (cmd.e_add)
        begin
            e_reg <= e_reg + prod_ext;
        end
        if (cmd.emit)
        begin
            div_reg  <= div_sat;
            skip_reg <= cnt_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            if (cmd.emit)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_sat;
                cnt_reg <= cnt_sat;
            end
        end
    end

    assign status.last   = last_reg;
    assign divergence    = div_reg;
    assign skipped_terms = skip_reg;

endmodule

### design/jensen_shannon_divergence.sv
// One element pair is taken at a time: accept, three table-interpolated
// logs and two weighted products all share one 31x18 multiplier, then accumulate;
// in_ready stays low until then. out_valid is registered, set by the final accumulate.
// The result sits in an output register; the block stalls only if a second result
// is due while the first is still untaken.
// Reset (rst_n, asynchronous) clears the controller, running sum and skip count.
module jensen_shannon_divergence #(
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [jsd_pkg::PROB_W-1:0]        prob_a,
    input  logic [jsd_pkg::PROB_W-1:0]        prob_b,
    input  logic                              last_element,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [jsd_pkg::DIV_W-1:0]  divergence,
    output logic [jsd_pkg::SKIP_W-1:0]        skipped_terms
);
    import jsd_pkg::*;

    jsd_cmd_t    cmd;
    jsd_status_t status;

    jsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    jsd_datapath #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .prob_a        (prob_a),
        .prob_b        (prob_b),
        .last_element  (last_element),
        .cmd           (cmd),
        .status        (status),
        .divergence    (divergence),
        .skipped_terms (skipped_terms)
    );

endmodule
